@@ sv/cfd_pkg.sv @@
// ----------------------------------------------------------------------------
// cfd_pkg
// Shared types, constants and helpers of the configurable frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package cfd_pkg;

    localparam int MAX_FRAME   = 64;
    localparam int MAX_PATTERN = 4;
    localparam int RESULT_CAP  = 64;
    localparam int ADDR_W      = $clog2(MAX_FRAME);
    localparam int FILL_W      = $clog2(MAX_FRAME + 1);
    localparam int CNT_W       = $clog2(RESULT_CAP + 1);
    localparam int PAT_LEN_W   = $clog2(MAX_PATTERN + 1);
    localparam int OVER_W      = 5;
    localparam int PAYLOAD_W   = 24;
    localparam int TOTAL_W     = 25;
    localparam int CFG_W       = 32;

    localparam logic [1:0] MODE_BYPASS = 2'd0;
    localparam logic [1:0] MODE_FIXED  = 2'd1;

    localparam logic [2:0] REG_MODE      = 3'd0;
    localparam logic [2:0] REG_HEAD_PAT  = 3'd1;
    localparam logic [2:0] REG_HEAD_LEN  = 3'd2;
    localparam logic [2:0] REG_TAIL_PAT  = 3'd3;
    localparam logic [2:0] REG_TAIL_LEN  = 3'd4;
    localparam logic [2:0] REG_LEN_FIELD = 3'd5;
    localparam logic [2:0] REG_CHECKSUM  = 3'd6;
    localparam logic [2:0] REG_FIXED_LEN = 3'd7;

    typedef struct packed {
        logic [1:0]           mode;
        logic [31:0]          head_pattern;
        logic [PAT_LEN_W-1:0] h;
        logic [31:0]          tail_pattern;
        logic [PAT_LEN_W-1:0] t;
        logic [1:0]           lf;
        logic [OVER_W-1:0]    over;
        logic [6:0]           fixed_len;
    } cfd_cfg_t;

    typedef struct packed {
        logic [FILL_W-1:0] fill;
        logic              busy;
    } cfd_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BYP_RD,
        ST_BYP_WR,
        ST_SCAN,
        ST_HEAD_RD,
        ST_HEAD_CK,
        ST_LEN,
        ST_LF_RD,
        ST_LF_CK,
        ST_SIZE,
        ST_TAIL_RD,
        ST_TAIL_CK,
        ST_EMIT_CHK,
        ST_EMIT_RD,
        ST_EMIT_WR
    } cfd_state_t;

    // byte i of a pattern of len bytes, first byte most significant
    function automatic logic [7:0] pat_byte(input logic [31:0] pat,
                                            input logic [PAT_LEN_W-1:0] len,
                                            input logic [PAT_LEN_W-1:0] i);
        logic [PAT_LEN_W-1:0] sel;
        logic [7:0]           b;
        sel = len - PAT_LEN_W'(1) - i;
        case (sel[1:0])
            2'd0:    b = pat[7:0];
            2'd1:    b = pat[15:8];
            2'd2:    b = pat[23:16];
            default: b = pat[31:24];
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

@@ sv/cfd_ram.sv @@
// ----------------------------------------------------------------------------
// cfd_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ sv/cfd_cfg.sv @@
// ----------------------------------------------------------------------------
// cfd_cfg
// Configuration register file; saturates pattern lengths, sums frame overhead.
// ----------------------------------------------------------------------------
`default_nettype none

module cfd_cfg
    import cfd_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [2:0]       cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    output      cfd_cfg_t         cfg
);

    logic [1:0]  mode_reg;
    logic [31:0] head_pat_reg;
    logic [2:0]  head_len_reg;
    logic [31:0] tail_pat_reg;
    logic [2:0]  tail_len_reg;
    logic [1:0]  lf_reg;
    logic [2:0]  cs_reg;
    logic [6:0]  fixed_reg;

    logic [PAT_LEN_W-1:0] h_sat;
    logic [PAT_LEN_W-1:0] t_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= '0;
            head_pat_reg <= '0;
            head_len_reg <= '0;
            tail_pat_reg <= '0;
            tail_len_reg <= '0;
            lf_reg       <= '0;
            cs_reg       <= '0;
            fixed_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE:      mode_reg     <= cfg_data[1:0];
                REG_HEAD_PAT:  head_pat_reg <= cfg_data[31:0];
                REG_HEAD_LEN:  head_len_reg <= cfg_data[2:0];
                REG_TAIL_PAT:  tail_pat_reg <= cfg_data[31:0];
                REG_TAIL_LEN:  tail_len_reg <= cfg_data[2:0];
                REG_LEN_FIELD: lf_reg       <= cfg_data[1:0];
                REG_CHECKSUM:  cs_reg       <= cfg_data[2:0];
                REG_FIXED_LEN: fixed_reg    <= cfg_data[6:0];
                default:       ;
            endcase
        end
    end

    // clamp pattern lengths to the widest pattern
    assign h_sat = (head_len_reg > 3'(MAX_PATTERN)) ? PAT_LEN_W'(MAX_PATTERN)
                                                     : PAT_LEN_W'(head_len_reg);
    assign t_sat = (tail_len_reg > 3'(MAX_PATTERN)) ? PAT_LEN_W'(MAX_PATTERN)
                                                     : PAT_LEN_W'(tail_len_reg);

    always_comb
    begin
        cfg.mode         = mode_reg;
        cfg.head_pattern = head_pat_reg;
        cfg.h            = h_sat;
        cfg.tail_pattern = tail_pat_reg;
        cfg.t            = t_sat;
        cfg.lf           = lf_reg;
        cfg.over         = OVER_W'(h_sat) + OVER_W'(lf_reg) + OVER_W'(cs_reg) + OVER_W'(t_sat);
        cfg.fixed_len    = fixed_reg;
    end

endmodule

`default_nettype wire

@@ sv/cfd_seq.sv @@
// ----------------------------------------------------------------------------
// cfd_seq
// Buffer sequencer: stores bytes, searches frames, drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cfd_seq
    import cfd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cfd_cfg_t          cfg,
    input  wire logic              in_valid,
    output      logic              in_stall,
    input  wire logic [7:0]        rx_byte,
    output      logic              out_valid,
    input  wire logic              out_stall,
    output      logic [7:0]        out_byte,
    output      logic              byte_present,
    output      logic              frame_last,
    output      logic              ram_we,
    output      logic [ADDR_W-1:0] ram_waddr,
    output      logic [7:0]        ram_wdata,
    output      logic              ram_re,
    output      logic [ADDR_W-1:0] ram_raddr,
    input  wire logic [7:0]        ram_rdata,
    output      cfd_stat_t         stat
);

    cfd_state_t           state_reg,   state_next;
    logic [ADDR_W-1:0]    start_reg,   start_next;
    logic [FILL_W-1:0]    fill_reg,    fill_next;
    logic [CNT_W-1:0]     count_reg,   count_next;
    logic [ADDR_W-1:0]    idx_reg,     idx_next;
    logic [PAYLOAD_W-1:0] payload_reg, payload_next;
    logic [TOTAL_W-1:0]   total_reg,   total_next;
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_byte_reg,  out_byte_next;
    logic                 present_reg,   present_next;
    logic                 last_reg,      last_next;

    logic                 accept;
    logic                 slot_free;
    logic [TOTAL_W-1:0]   tot;
    logic [CNT_W-1:0]     need;
    logic                 emit_last;

    assign accept    = in_valid && !in_stall;
    assign slot_free = !out_valid_reg;
    assign tot       = (cfg.mode == MODE_FIXED) ? TOTAL_W'(cfg.fixed_len)
                                                : TOTAL_W'(payload_reg) + TOTAL_W'(cfg.over);
    assign need      = (payload_reg == '0) ? CNT_W'(1) : CNT_W'(payload_reg);
    assign emit_last = (PAYLOAD_W'(idx_reg) + PAYLOAD_W'(1)) == payload_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= '0;
            fill_reg      <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            fill_reg      <= fill_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        payload_reg  <= payload_next;
        total_reg    <= total_next;
        out_byte_reg <= out_byte_next;
        present_reg  <= present_next;
        last_reg     <= last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        start_next     = start_reg;
        fill_next      = fill_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        payload_next   = payload_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        present_next   = present_reg;
        last_next      = last_reg;
        in_stall       = (state_reg != ST_IDLE);
        ram_we         = 1'b0;
        ram_waddr      = start_reg + fill_reg[ADDR_W-1:0];
        ram_wdata      = rx_byte;
        ram_re         = 1'b0;
        ram_raddr      = start_reg;

        // retire a taken result
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ram_we     = 1'b1;
                    count_next = '0;
                    // full buffer: the new byte overwrites the oldest one
                    if (fill_reg == FILL_W'(MAX_FRAME))
                    begin
                        start_next = start_reg + ADDR_W'(1);
                    end
                    else
                    begin
                        fill_next = fill_reg + FILL_W'(1);
                    end
                    state_next = (cfg.mode == MODE_BYPASS) ? ST_BYP_RD : ST_SCAN;
                end
            end

            ST_BYP_RD:
            begin
                if (fill_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else if (slot_free)
                begin
                    ram_re     = 1'b1;
                    state_next = ST_BYP_WR;
                end
            end

            ST_BYP_WR:
            begin
                out_valid_next = 1'b1;
                out_byte_next  = ram_rdata;
                present_next   = 1'b1;
                last_next      = 1'b1;
                start_next     = start_reg + ADDR_W'(1);
                fill_next      = fill_reg - FILL_W'(1);
                state_next     = ST_BYP_RD;
            end

            ST_SCAN:
            begin
                idx_next = '0;
                if (fill_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else if (cfg.h != '0)
                begin
                    state_next = (fill_reg < FILL_W'(cfg.h)) ? ST_IDLE : ST_HEAD_RD;
                end
                else
                begin
                    state_next = ST_LEN;
                end
            end

            ST_HEAD_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = start_reg + idx_reg;
                state_next = ST_HEAD_CK;
            end

            ST_HEAD_CK:
            begin
                if (ram_rdata != pat_byte(cfg.head_pattern, cfg.h, PAT_LEN_W'(idx_reg)))
                begin
                    start_next = start_reg + ADDR_W'(1);
                    fill_next  = fill_reg - FILL_W'(1);
                    state_next = ST_SCAN;
                end
                else if (idx_reg + ADDR_W'(1) == ADDR_W'(cfg.h))
                begin
                    state_next = ST_LEN;
                end
                else
                begin
                    idx_next   = idx_reg + ADDR_W'(1);
                    state_next = ST_HEAD_RD;
                end
            end

            ST_LEN:
            begin
                idx_next     = '0;
                payload_next = '0;
                if (cfg.mode == MODE_FIXED)
                begin
                    if (cfg.fixed_len == '0 || cfg.fixed_len < 7'(cfg.over))
                    begin
                        start_next = start_reg + ADDR_W'(1);
                        fill_next  = fill_reg - FILL_W'(1);
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        payload_next = PAYLOAD_W'(cfg.fixed_len - 7'(cfg.over));
                        state_next   = ST_SIZE;
                    end
                end
                else if (fill_reg < FILL_W'(cfg.over))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = (cfg.lf == '0) ? ST_SIZE : ST_LF_RD;
                end
            end

            ST_LF_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = start_reg + ADDR_W'(cfg.h) + idx_reg;
                state_next = ST_LF_CK;
            end

            ST_LF_CK:
            begin
                payload_next = {payload_reg[PAYLOAD_W-9:0], ram_rdata};
                idx_next     = idx_reg + ADDR_W'(1);
                state_next   = (idx_reg + ADDR_W'(1) == ADDR_W'(cfg.lf)) ? ST_SIZE : ST_LF_RD;
            end

            ST_SIZE:
            begin
                idx_next   = '0;
                total_next = tot;
                if (tot == '0 || tot > TOTAL_W'(MAX_FRAME)
                    || payload_reg > PAYLOAD_W'(RESULT_CAP))
                begin
                    start_next = start_reg + ADDR_W'(1);
                    fill_next  = fill_reg - FILL_W'(1);
                    state_next = ST_SCAN;
                end
                else if (TOTAL_W'(fill_reg) < tot)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = (cfg.t != '0) ? ST_TAIL_RD : ST_EMIT_CHK;
                end
            end

            ST_TAIL_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = start_reg + total_reg[ADDR_W-1:0] - ADDR_W'(cfg.t) + idx_reg;
                state_next = ST_TAIL_CK;
            end

            ST_TAIL_CK:
            begin
                if (ram_rdata != pat_byte(cfg.tail_pattern, cfg.t, PAT_LEN_W'(idx_reg)))
                begin
                    start_next = start_reg + ADDR_W'(1);
                    fill_next  = fill_reg - FILL_W'(1);
                    state_next = ST_SCAN;
                end
                else if (idx_reg + ADDR_W'(1) == ADDR_W'(cfg.t))
                begin
                    idx_next   = '0;
                    state_next = ST_EMIT_CHK;
                end
                else
                begin
                    idx_next   = idx_reg + ADDR_W'(1);
                    state_next = ST_TAIL_RD;
                end
            end

            ST_EMIT_CHK:
            begin
                if ((CNT_W + 1)'(count_reg) + (CNT_W + 1)'(need) > (CNT_W + 1)'(RESULT_CAP))
                begin
                    state_next = ST_IDLE;
                end
                else if (payload_reg != '0)
                begin
                    state_next = ST_EMIT_RD;
                end
                else if (slot_free)
                begin
                    // empty payload: a single marker result
                    out_valid_next = 1'b1;
                    out_byte_next  = '0;
                    present_next   = 1'b0;
                    last_next      = 1'b1;
                    count_next     = count_reg + CNT_W'(1);
                    start_next     = start_reg + total_reg[ADDR_W-1:0];
                    fill_next      = fill_reg - total_reg[FILL_W-1:0];
                    state_next     = ST_SCAN;
                end
            end

            ST_EMIT_RD:
            begin
                if (slot_free)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = start_reg + ADDR_W'(cfg.h) + ADDR_W'(cfg.lf) + idx_reg;
                    state_next = ST_EMIT_WR;
                end
            end

            ST_EMIT_WR:
            begin
                out_valid_next = 1'b1;
                out_byte_next  = ram_rdata;
                present_next   = 1'b1;
                last_next      = emit_last;
                count_next     = count_reg + CNT_W'(1);
                if (emit_last)
                begin
                    start_next = start_reg + total_reg[ADDR_W-1:0];
                    fill_next  = fill_reg - total_reg[FILL_W-1:0];
                    state_next = ST_SCAN;
                end
                else
                begin
                    idx_next   = idx_reg + ADDR_W'(1);
                    state_next = ST_EMIT_RD;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign byte_present = present_reg;
    assign frame_last   = last_reg;

    always_comb
    begin
        stat.fill = fill_reg;
        stat.busy = (state_reg != ST_IDLE);
    end

endmodule

`default_nettype wire

@@ sv/configurable_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// configurable_frame_deframer
// Byte-stream deframer: head/length/tail frame search over a ring buffer.
// ----------------------------------------------------------------------------
// Timing: a byte is stored in the cycle it is taken; work that follows reads
// the ring buffer RAM a byte at a time, first the address, then the data.
// Framed mode reads the head, length field and tail bytes of each candidate
// start, then each payload byte; a rejected start is dropped and the search
// runs again from the next offset.
// Reset clears state, pointers, fill count and output valid; data registers and buffer contents are unknown.
`default_nettype none

module configurable_frame_deframer
    import cfd_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [2:0]       cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    input  wire logic             in_valid,
    output      logic             in_stall,
    input  wire logic [7:0]       rx_byte,
    output      logic             out_valid,
    input  wire logic             out_stall,
    output      logic [7:0]       out_byte,
    output      logic             byte_present,
    output      logic             frame_last
);

    cfd_cfg_t          cfg;
    cfd_stat_t         stat;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    // configuration registers and derived frame overhead
    cfd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // ring buffer holding received bytes, oldest at the start pointer
    cfd_ram #(
        .WIDTH (8),
        .DEPTH (MAX_FRAME)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // sequencer: store each transfer, then search and emit frames
    cfd_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .byte_present (byte_present),
        .frame_last   (frame_last),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_re       (ram_re),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .stat         (stat)
    );

    // buffer never holds more than its depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stat.fill <= FILL_W'(MAX_FRAME))
        else $error("fill count above buffer depth");

    // an accepted byte leaves the buffer non-empty
    a_fill_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> stat.fill != '0)
        else $error("buffer empty after input transfer");

    // an accepted byte starts work, so input stalls next cycle
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall && stat.busy)
        else $error("sequencer not busy after input transfer");

    // an empty-payload marker always closes its frame
    a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_present |-> frame_last)
        else $error("empty marker without frame end");

endmodule

`default_nettype wire

@@ test/tb_configurable_frame_deframer.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_configurable_frame_deframer
// Drives byte streams through the deframer in bypass, fixed-length and
// length-field modes. A built-in frame predictor tracks the ring buffer and
// the registers, and each output transfer is compared with the oldest
// expected payload byte.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_configurable_frame_deframer;
    import cfd_pkg::*;

    localparam logic [1:0] MODE_FIELD = 2'd2;
    localparam logic [1:0] MODE_ALIAS = 2'd3; // unused code, acts as MODE_FIELD
    localparam int SETTLE_CYCLES = 2000;      // worst rescan of a full buffer
    localparam int CYCLE_LIMIT   = 1000000;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [2:0]       cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic [7:0]       rx_byte = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [7:0]       out_byte;
    logic             byte_present;
    logic             frame_last;

    configurable_frame_deframer dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
        .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
        .byte_present(byte_present), .frame_last(frame_last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    typedef struct {
        logic [7:0] data;
        logic       present;
        logic       last;
    } frame_out_t;

    frame_out_t payload_due[$];

    // shadow registers
    logic [1:0]  sh_mode;
    logic [31:0] sh_head_pat, sh_tail_pat;
    logic [2:0]  sh_head_len, sh_tail_len, sh_chk;
    logic [1:0]  sh_lf;
    logic [6:0]  sh_fixed;

    // shadow ring buffer
    logic [7:0] ring [MAX_FRAME];
    int         ring_fill;
    int         ring_start;

    int errors;
    int cycles;
    int items_sent;
    int idle_pct;
    int stall_pct;

    // ------------------------------------------------------------------
    // frame predictor
    // ------------------------------------------------------------------
    function automatic logic [7:0] ring_at(int i);
        return ring[(ring_start + i) % MAX_FRAME];
    endfunction

    function automatic void ring_drop(int n);
        if (n > ring_fill)
            n = ring_fill;
        ring_start = (ring_start + n) % MAX_FRAME;
        ring_fill -= n;
    endfunction

    function automatic logic [7:0] pat_sel(logic [31:0] pat, int len, int i);
        return 8'(pat >> (8 * (len - 1 - i)));
    endfunction

    function automatic void due_push(logic [7:0] d, logic p, logic l);
        frame_out_t r;
        r.data = d;
        r.present = p;
        r.last = l;
        payload_due.push_back(r);
    endfunction

    function automatic void predict_byte(logic [7:0] b);
        int  cnt, n, h, t, lf, over, total, plen, need;
        bit  ok;
        cnt = 0;
        if (ring_fill >= MAX_FRAME)
            ring_drop(1);
        ring[(ring_start + ring_fill) % MAX_FRAME] = b;
        ring_fill++;
        if (sh_mode == MODE_BYPASS)
        begin
            while (ring_fill > 0 && cnt < RESULT_CAP)
            begin
                due_push(ring_at(0), 1'b1, 1'b1);
                cnt++;
                ring_drop(1);
            end
            return;
        end
        while (ring_fill > 0)
        begin
            n = ring_fill;
            h = (sh_head_len > MAX_PATTERN) ? MAX_PATTERN : int'(sh_head_len);
            t = (sh_tail_len > MAX_PATTERN) ? MAX_PATTERN : int'(sh_tail_len);
            lf = sh_lf;
            over = h + lf + sh_chk + t;
            ok = 1'b1;
            if (h > 0)
            begin
                if (n < h)
                    break;
                for (int i = 0; i < h; i++)
                    if (ring_at(i) != pat_sel(sh_head_pat, h, i))
                        ok = 1'b0;
                if (!ok)
                begin
                    ring_drop(1);
                    continue;
                end
            end
            if (sh_mode == MODE_FIXED)
            begin
                total = sh_fixed;
                if (total == 0 || total < over)
                begin
                    ring_drop(1);
                    continue;
                end
                plen = total - over;
            end
            else
            begin
                if (n < over)
                    break;
                plen = 0;
                for (int i = 0; i < lf; i++)
                    plen = (plen << 8) | ring_at(h + i);
                total = over + plen;
                if (total == 0)
                begin
                    ring_drop(1);
                    continue;
                end
            end
            if (total > MAX_FRAME || plen > RESULT_CAP)
            begin
                ring_drop(1);
                continue;
            end
            if (n < total)
                break;
            for (int i = 0; i < t; i++)
                if (ring_at(total - t + i) != pat_sel(sh_tail_pat, t, i))
                    ok = 1'b0;
            if (!ok)
            begin
                ring_drop(1);
                continue;
            end
            need = (plen != 0) ? plen : 1;
            if (cnt + need > RESULT_CAP)
                break;
            if (plen == 0)
            begin
                due_push(8'h00, 1'b0, 1'b1);
                cnt++;
            end
            else
                for (int i = 0; i < plen; i++)
                begin
                    due_push(ring_at(h + lf + i), 1'b1, (i + 1 == plen));
                    cnt++;
                end
            ring_drop(total);
        end
    endfunction

    // ------------------------------------------------------------------
    // output checker and receiver stall
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (payload_due.size() == 0)
            begin
                $display("%0t unexpected output: byte %h present %b last %b",
                         $time, out_byte, byte_present, frame_last);
                errors++;
            end
            else
            begin
                frame_out_t exp_r;
                exp_r = payload_due.pop_front();
                if (out_byte !== exp_r.data || byte_present !== exp_r.present
                    || frame_last !== exp_r.last)
                begin
                    $display("%0t mismatch: expected byte %h present %b last %b, got %h %b %b",
                             $time, exp_r.data, exp_r.present, exp_r.last,
                             out_byte, byte_present, frame_last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // hard stop if the block hangs
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // shared tasks
    // ------------------------------------------------------------------
    task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MODE:      sh_mode = val[1:0];
            REG_HEAD_PAT:  sh_head_pat = val;
            REG_HEAD_LEN:  sh_head_len = val[2:0];
            REG_TAIL_PAT:  sh_tail_pat = val;
            REG_TAIL_LEN:  sh_tail_len = val[2:0];
            REG_LEN_FIELD: sh_lf = val[1:0];
            REG_CHECKSUM:  sh_chk = val[2:0];
            default:       sh_fixed = val[6:0];
        endcase
        @(posedge clk);
    endtask

    // one transfer on the input channel, then maybe an idle gap
    task automatic send_byte(logic [7:0] b);
        in_valid <= 1'b1;
        rx_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        predict_byte(b);
        items_sent++;
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic hold_input();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (payload_due.size() != 0)
            @(posedge clk);
    endtask

    // drain and let any rescan finish before touching registers
    task automatic settle();
        hold_input();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // build one frame for the current registers; spoil flips one byte
    task automatic send_frame(int plen, bit spoil);
        logic [7:0] fb [$];
        int h, t, idx;
        h = (sh_head_len > MAX_PATTERN) ? MAX_PATTERN : int'(sh_head_len);
        t = (sh_tail_len > MAX_PATTERN) ? MAX_PATTERN : int'(sh_tail_len);
        if (sh_mode == MODE_FIXED)
            plen = int'(sh_fixed) - (h + sh_lf + sh_chk + t);
        if (plen < 0)
            plen = 0;
        for (int i = 0; i < h; i++)
            fb.push_back(pat_sel(sh_head_pat, h, i));
        for (int i = 0; i < sh_lf; i++)
            fb.push_back(8'(plen >> (8 * (sh_lf - 1 - i))));
        for (int i = 0; i < plen + sh_chk; i++)
            fb.push_back(8'($urandom));
        for (int i = 0; i < t; i++)
            fb.push_back(pat_sel(sh_tail_pat, t, i));
        if (fb.size() == 0)
            fb.push_back(8'($urandom));
        if (spoil)
        begin
            idx = $urandom_range(fb.size() - 1);
            fb[idx] = fb[idx] ^ 8'($urandom_range(1, 255));
        end
        foreach (fb[i])
            send_byte(fb[i]);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_bypass();
        cfg_write(REG_MODE, MODE_BYPASS);
        cfg_write(REG_HEAD_PAT, 32'h0);
        cfg_write(REG_HEAD_LEN, 0);
        cfg_write(REG_TAIL_PAT, 32'h0);
        cfg_write(REG_TAIL_LEN, 0);
        cfg_write(REG_LEN_FIELD, 0);
        cfg_write(REG_CHECKSUM, 0);
        cfg_write(REG_FIXED_LEN, 0);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h55);
        send_byte(8'hAA);
        settle();
    endtask

    task automatic test_fixed_frames();
        cfg_write(REG_MODE, MODE_FIXED);
        cfg_write(REG_HEAD_PAT, 32'h0000A55A);
        cfg_write(REG_HEAD_LEN, 2);
        cfg_write(REG_TAIL_PAT, 32'h0000000D);
        cfg_write(REG_TAIL_LEN, 1);
        cfg_write(REG_CHECKSUM, 1);
        cfg_write(REG_FIXED_LEN, 6);
        send_frame(0, 1'b0);
        // hold the sender until the whole frame has come out
        hold_input();
        wait_drained();
        send_frame(0, 1'b1);
        send_frame(0, 1'b0);
        settle();
        // too short for its own overhead, then zero length, then oversize
        cfg_write(REG_FIXED_LEN, 3);
        send_byte(8'hA5);
        send_byte(8'h5A);
        settle();
        cfg_write(REG_FIXED_LEN, 0);
        send_byte(8'hA5);
        settle();
        cfg_write(REG_FIXED_LEN, 127);
        send_byte(8'h5A);
        settle();
    endtask

    task automatic test_length_field();
        cfg_write(REG_MODE, MODE_FIELD);
        cfg_write(REG_HEAD_PAT, 32'hDEADBEEF);
        cfg_write(REG_HEAD_LEN, 7);           // saturates to four bytes
        cfg_write(REG_TAIL_PAT, 32'h0000CAFE);
        cfg_write(REG_TAIL_LEN, 2);
        cfg_write(REG_LEN_FIELD, 1);
        cfg_write(REG_CHECKSUM, 0);
        send_frame(0, 1'b0);                  // empty payload marker
        send_frame(1, 1'b0);
        settle();
        // length field of three bytes under the unused mode code
        cfg_write(REG_MODE, MODE_ALIAS);
        cfg_write(REG_LEN_FIELD, 3);
        cfg_write(REG_HEAD_LEN, 0);
        cfg_write(REG_TAIL_LEN, 0);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'hFF);                     // oversize length, rescans
        send_frame(1, 1'b0);
        settle();
    endtask

    // bytes left buffered in a framed mode leave first in bypass
    task automatic test_leftover_bypass();
        cfg_write(REG_MODE, MODE_FIELD);
        cfg_write(REG_LEN_FIELD, 1);
        cfg_write(REG_CHECKSUM, 0);
        send_byte(8'h05);
        send_byte(8'h11);
        settle();
        cfg_write(REG_MODE, MODE_BYPASS);
        send_byte(8'h22);
        settle();
    endtask

    task automatic random_config();
        int over, sel;
        sel = $urandom_range(9);
        cfg_write(REG_MODE, (sel < 4) ? MODE_FIXED : (sel < 9) ? MODE_FIELD : MODE_ALIAS);
        cfg_write(REG_HEAD_PAT, $urandom);
        cfg_write(REG_HEAD_LEN, $urandom_range(0, 7));
        cfg_write(REG_TAIL_PAT, $urandom);
        cfg_write(REG_TAIL_LEN, $urandom_range(0, 7));
        cfg_write(REG_LEN_FIELD, $urandom_range(1, 2));
        cfg_write(REG_CHECKSUM, $urandom_range(0, 7));
        over = ((sh_head_len > 4) ? 4 : sh_head_len) + ((sh_tail_len > 4) ? 4 : sh_tail_len)
               + sh_chk + ((sh_mode == MODE_FIXED) ? sh_lf : 0);
        cfg_write(REG_FIXED_LEN, ($urandom_range(9) == 0) ? 64 : over + $urandom_range(0, 8));
    endtask

    task automatic test_random_phase(int idle, int stall, int quota);
        int start_cnt, r;
        idle_pct = idle;
        stall_pct = stall;
        start_cnt = items_sent;
        random_config();
        while (items_sent - start_cnt < quota)
        begin
            r = $urandom_range(99);
            if (r < 75)
                send_frame(($urandom_range(19) == 0) ? $urandom_range(20, 64)
                                                     : $urandom_range(0, 6), 1'b0);
            else if (r < 88)
                send_frame($urandom_range(0, 6), 1'b1);
            else
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
        end
        settle();
    endtask

    // fixed length 64 with no overhead: one full-width frame per buffer
    task automatic test_full_frame();
        cfg_write(REG_MODE, MODE_FIXED);
        cfg_write(REG_HEAD_LEN, 0);
        cfg_write(REG_TAIL_LEN, 0);
        cfg_write(REG_LEN_FIELD, 0);
        cfg_write(REG_CHECKSUM, 0);
        cfg_write(REG_FIXED_LEN, 64);
        send_frame(0, 1'b0);
        settle();
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        items_sent = 0;
        idle_pct = 0;
        stall_pct = 0;
        ring_fill = 0;
        ring_start = 0;
        sh_mode = MODE_BYPASS;
        sh_head_pat = '0;
        sh_tail_pat = '0;
        sh_head_len = '0;
        sh_tail_len = '0;
        sh_chk = '0;
        sh_lf = '0;
        sh_fixed = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge clk);

        test_bypass();
        test_fixed_frames();
        test_length_field();
        test_leftover_bypass();
        test_full_frame();
        test_random_phase(0, 0, 10);
        test_random_phase(84, 0, 10);
        test_random_phase(0, 84, 10);
        test_random_phase(22, 22, 10);

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
sv/cfd_pkg.sv
sv/cfd_ram.sv
sv/cfd_cfg.sv
sv/cfd_seq.sv
sv/configurable_frame_deframer.sv
test/tb_configurable_frame_deframer.sv
